// ===== src/kbrs_pkg.sv =====
// Shared widths, register indexes and structs for the kd brick region split.
// No dependencies; every other file in src imports this package.
package kbrs_pkg;

    // Field widths fixed by the item format
    localparam int RANK_W  = 10;
    localparam int NRANK_W = 11;
    localparam int COORD_W = 16;
    localparam int LEFT_W  = NRANK_W - 1;
    localparam int PROD_W  = LEFT_W + COORD_W;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] REG_NUM_RANKS = 2'd0;
    localparam logic [1:0] REG_EXTENT_X  = 2'd1;
    localparam logic [1:0] REG_EXTENT_Y  = 2'd2;
    localparam logic [1:0] REG_EXTENT_Z  = 2'd3;

    typedef struct packed {
        logic [NRANK_W-1:0] num_ranks;
        logic [COORD_W-1:0] extent_x;
        logic [COORD_W-1:0] extent_y;
        logic [COORD_W-1:0] extent_z;
    } t_cfg;

    typedef struct packed {
        logic               start;
        logic [PROD_W-1:0]  dividend;
        logic [NRANK_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] quotient;
    } t_div_rsp;

endpackage

// ===== src/kbrs_if.sv =====
// Valid/ready channel interfaces for rank requests and brick region results.
// Depends on kbrs_pkg for the field widths.
interface kbrs_req_if;
    import kbrs_pkg::*;
    logic              valid;
    logic              ready;
    logic [RANK_W-1:0] rank_in;

    modport source (output valid, output rank_in, input ready);
    modport sink   (input valid, input rank_in, output ready);
endinterface

interface kbrs_resp_if;
    import kbrs_pkg::*;
    logic               valid;
    logic               ready;
    logic [RANK_W-1:0]  brick_id;
    logic [COORD_W-1:0] low_x;
    logic [COORD_W-1:0] low_y;
    logic [COORD_W-1:0] low_z;
    logic [COORD_W-1:0] high_x;
    logic [COORD_W-1:0] high_y;
    logic [COORD_W-1:0] high_z;
    logic               rank_ok;

    modport source (output valid, output brick_id, output low_x, output low_y, output low_z,
                    output high_x, output high_y, output high_z, output rank_ok,
                    input ready);
    modport sink   (input valid, input brick_id, input low_x, input low_y, input low_z,
                    input high_x, input high_y, input high_z, input rank_ok,
                    output ready);
endinterface

// ===== src/kbrs_cfg.sv =====
// APB-style register file: rank count and the three volume extents.
// Depends on kbrs_pkg.
module kbrs_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kbrs_pkg::PADDR_W-1:0] paddr,
    input  logic [kbrs_pkg::PDATA_W-1:0] pwdata,
    output logic [kbrs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output kbrs_pkg::t_cfg               o_cfg
);
    import kbrs_pkg::*;

    t_cfg       r_cfg;
    t_cfg       n_cfg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    // Decode the write beat
    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_idx)
                REG_NUM_RANKS: n_cfg.num_ranks = pwdata[NRANK_W-1:0];
                REG_EXTENT_X:  n_cfg.extent_x  = pwdata[COORD_W-1:0];
                REG_EXTENT_Y:  n_cfg.extent_y  = pwdata[COORD_W-1:0];
                REG_EXTENT_Z:  n_cfg.extent_z  = pwdata[COORD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.num_ranks <= NRANK_W'(1);
            r_cfg.extent_x  <= COORD_W'(1);
            r_cfg.extent_y  <= COORD_W'(1);
            r_cfg.extent_z  <= COORD_W'(1);
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Read back, zero extended
    always_comb begin
        case (reg_idx)
            REG_NUM_RANKS: prdata = PDATA_W'(r_cfg.num_ranks);
            REG_EXTENT_X:  prdata = PDATA_W'(r_cfg.extent_x);
            REG_EXTENT_Y:  prdata = PDATA_W'(r_cfg.extent_y);
            REG_EXTENT_Z:  prdata = PDATA_W'(r_cfg.extent_z);
            default:       prdata = '0;
        endcase
    end

endmodule

// ===== src/kbrs_div.sv =====
// Serial restoring divider, one quotient bit per cycle, for the cut position.
// Depends on kbrs_pkg. The quotient is known to fit in COORD_W bits.
module kbrs_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kbrs_pkg::t_div_req i_req,
    output kbrs_pkg::t_div_rsp o_rsp
);
    import kbrs_pkg::*;

    localparam int CNT_W = $clog2(COORD_W + 1);

    logic               r_busy, n_busy;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [NRANK_W-1:0] r_rem, n_rem;
    logic [NRANK_W-1:0] r_dvs, n_dvs;
    logic [COORD_W-1:0] r_acc, n_acc;
    logic               r_done, n_done;
    logic [NRANK_W:0]   trial;
    logic [NRANK_W:0]   diff;
    logic               ge;

    // Shift in the next dividend bit and try the subtract
    assign trial = {r_rem, r_acc[COORD_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = trial >= {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_acc  = r_acc;
        n_done = 1'b0;
        if (!r_busy && i_req.start) begin
            // High part of the dividend is already below the divisor
            n_busy = 1'b1;
            n_cnt  = CNT_W'(COORD_W);
            n_rem  = NRANK_W'(i_req.dividend[PROD_W-1:COORD_W]);
            n_acc  = i_req.dividend[COORD_W-1:0];
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[NRANK_W-1:0] : trial[NRANK_W-1:0];
            n_acc = {r_acc[COORD_W-2:0], ge};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_acc <= n_acc;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_acc;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_cnt == CNT_W'(1)) |=> (o_rsp.done && !r_busy))
        else $error("divider did not finish after its last step");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.done |-> !r_busy)
        else $error("divider flagged done while still busy");

endmodule

// ===== src/kd_brick_region_split.sv =====
// kd brick region split: rank in, owned voxel box out, by recursive bisection.
// Flow for a valid rank: accept, then for each of L = ceil(log2(ranks)) levels (at most 10)
// the level, multiply, divider start and divider wait states around the 16-step serial divider,
// then finish; an invalid rank goes straight to finish. One request at a time: a new rank is taken
// only when idle; a finished result may wait in the output register while the next request is taken.
// Synchronous active-low reset idles the sequencer, drops output valid, sets ranks/extents to 1.
module kd_brick_region_split #(
    parameter int MAX_RANKS  = 1024,
    parameter int COORD_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    kbrs_req_if.sink                     i_req,
    kbrs_resp_if.source                  o_resp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [kbrs_pkg::PADDR_W-1:0] paddr,
    input  logic [kbrs_pkg::PDATA_W-1:0] pwdata,
    output logic [kbrs_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import kbrs_pkg::*;

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_LEVEL   = 3'd1;
    localparam logic [2:0] S_MUL     = 3'd2;
    localparam logic [2:0] S_DIVGO   = 3'd3;
    localparam logic [2:0] S_DIVWAIT = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    localparam int MaskBits = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
    localparam logic [COORD_W-1:0] ExtMask = COORD_W'((64'd1 << MaskBits) - 64'd1);

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [2:0]              r_state, n_state;
    logic [RANK_W-1:0]       r_id, n_id;
    logic [RANK_W-1:0]       r_rank, n_rank;
    logic [NRANK_W-1:0]      r_n, n_n;
    logic                    r_ok, n_ok;
    logic [2:0][COORD_W-1:0] r_lo, n_lo;
    logic [2:0][COORD_W-1:0] r_hi, n_hi;
    logic [1:0]              r_axis, n_axis;
    logic [COORD_W-1:0]      r_size, n_size;
    logic [LEFT_W-1:0]       r_left, n_left;
    logic [PROD_W-1:0]       r_prod, n_prod;

    logic                    r_out_valid, n_out_valid;
    logic [RANK_W-1:0]       r_out_id, n_out_id;
    logic                    r_out_ok, n_out_ok;
    logic [2:0][COORD_W-1:0] r_out_lo, n_out_lo;
    logic [2:0][COORD_W-1:0] r_out_hi, n_out_hi;

    logic [NRANK_W-1:0]      n_eff;
    logic [2:0][COORD_W-1:0] ext_hi;
    logic [2:0][COORD_W-1:0] sz;
    logic [1:0]              axis_01;
    logic [1:0]              axis_sel;
    logic [COORD_W-1:0]      cut;
    logic                    out_free;

    kbrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    kbrs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Clamp the rank count and turn extents into upper corners
    assign n_eff = (32'(cfg.num_ranks) > MAX_RANKS) ? NRANK_W'(MAX_RANKS) : cfg.num_ranks;

    always_comb begin
        logic [2:0][COORD_W-1:0] ext;
        ext[0] = cfg.extent_x & ExtMask;
        ext[1] = cfg.extent_y & ExtMask;
        ext[2] = cfg.extent_z & ExtMask;
        for (int k = 0; k < 3; k++) begin
            ext_hi[k] = (ext[k] == '0) ? '0 : ext[k] - COORD_W'(1);
        end
    end

    // Widest axis, lowest index on a tie
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            sz[k] = r_hi[k] - r_lo[k];
        end
        axis_01  = (sz[1] > sz[0]) ? 2'd1 : 2'd0;
        axis_sel = (sz[2] > sz[axis_01]) ? 2'd2 : axis_01;
    end

    assign cut      = r_lo[r_axis] + div_rsp.quotient;
    assign out_free = !r_out_valid || o_resp.ready;

    assign div_req.start    = (r_state == S_DIVGO);
    assign div_req.dividend = r_prod;
    assign div_req.divisor  = r_n;

    assign i_req.ready = (r_state == S_IDLE);

    // Sequencer: one bisection level per pass through the divider
    always_comb begin
        n_state = r_state;
        n_id    = r_id;
        n_rank  = r_rank;
        n_n     = r_n;
        n_ok    = r_ok;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_axis  = r_axis;
        n_size  = r_size;
        n_left  = r_left;
        n_prod  = r_prod;
        n_out_valid = r_out_valid && !o_resp.ready;
        n_out_id    = r_out_id;
        n_out_ok    = r_out_ok;
        n_out_lo    = r_out_lo;
        n_out_hi    = r_out_hi;
        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_id   = i_req.rank_in;
                    n_rank = i_req.rank_in;
                    n_n    = n_eff;
                    n_lo   = '0;
                    n_hi   = ext_hi;
                    n_ok   = {1'b0, i_req.rank_in} < n_eff;
                    n_state = ({1'b0, i_req.rank_in} < n_eff) ? S_LEVEL : S_FIN;
                end
            end
            S_LEVEL: begin
                if (r_n <= NRANK_W'(1)) begin
                    n_state = S_FIN;
                end else begin
                    n_axis  = axis_sel;
                    n_size  = sz[axis_sel];
                    n_left  = r_n[NRANK_W-1:1];
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_left) * PROD_W'(r_size);
                n_state = S_DIVGO;
            end
            S_DIVGO: begin
                n_state = S_DIVWAIT;
            end
            S_DIVWAIT: begin
                if (div_rsp.done) begin
                    // Descend into the half that holds the rank
                    if (r_rank >= r_left) begin
                        n_lo[r_axis] = cut;
                        n_rank = r_rank - r_left;
                        n_n    = r_n - {1'b0, r_left};
                    end else begin
                        n_hi[r_axis] = cut;
                        n_n    = {1'b0, r_left};
                    end
                    n_state = S_LEVEL;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_id    = r_id;
                    n_out_ok    = r_ok;
                    n_out_lo    = r_ok ? r_lo : '0;
                    n_out_hi    = r_ok ? r_hi : '0;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id     <= n_id;
        r_rank   <= n_rank;
        r_n      <= n_n;
        r_ok     <= n_ok;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_axis   <= n_axis;
        r_size   <= n_size;
        r_left   <= n_left;
        r_prod   <= n_prod;
        r_out_id <= n_out_id;
        r_out_ok <= n_out_ok;
        r_out_lo <= n_out_lo;
        r_out_hi <= n_out_hi;
    end

    // Drive the result beat
    assign o_resp.valid    = r_out_valid;
    assign o_resp.brick_id = r_out_id;
    assign o_resp.rank_ok  = r_out_ok;
    assign o_resp.low_x    = r_out_lo[0];
    assign o_resp.low_y    = r_out_lo[1];
    assign o_resp.low_z    = r_out_lo[2];
    assign o_resp.high_x   = r_out_hi[0];
    assign o_resp.high_y   = r_out_hi[1];
    assign o_resp.high_z   = r_out_hi[2];

    a_invalid_zero_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp.valid && !o_resp.rank_ok) |->
            (o_resp.low_x == '0 && o_resp.low_y == '0 && o_resp.low_z == '0 &&
             o_resp.high_x == '0 && o_resp.high_y == '0 && o_resp.high_z == '0))
        else $error("invalid rank returned a non-empty box");

    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_resp.valid && o_resp.rank_ok) |->
            (o_resp.low_x <= o_resp.high_x && o_resp.low_y <= o_resp.high_y &&
             o_resp.low_z <= o_resp.high_z))
        else $error("brick box has a lower corner above its upper corner");

    a_rank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LEVEL) |-> (r_n != '0 && {1'b0, r_rank} < r_n))
        else $error("remaining rank outside the remaining rank count");

endmodule

// ===== tb/tb_kd_brick_region_split.sv =====
// Self-checking testbench for kd_brick_region_split: rank requests in, brick boxes out.
// Registers are set over APB, and every box is predicted by an in-bench bisection walk.
// Depends on kbrs_pkg (src/kbrs_pkg.sv) and the channel interfaces in src/kbrs_if.sv.
module tb_kd_brick_region_split;
    import kbrs_pkg::*;

    localparam int RANK_LIMIT      = 1024;
    localparam int HOLD_CYCLES     = 800;
    localparam int DRAIN_CYCLES    = 300;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 105;

    // One expected brick box, one field per output of the result channel
    typedef struct packed {
        logic [RANK_W-1:0]  brick_id;
        logic [COORD_W-1:0] low_x;
        logic [COORD_W-1:0] low_y;
        logic [COORD_W-1:0] low_z;
        logic [COORD_W-1:0] high_x;
        logic [COORD_W-1:0] high_y;
        logic [COORD_W-1:0] high_z;
        logic               rank_ok;
    } t_region;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    kbrs_req_if  req_ch ();
    kbrs_resp_if resp_ch ();

    kd_brick_region_split #(
        .MAX_RANKS  (RANK_LIMIT),
        .COORD_BITS (COORD_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_resp  (resp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_cfg     volume_cfg;
    t_region  region_queue[$];
    t_region  region_due;
    int       mismatch_count  = 0;
    int       ranks_sent      = 0;
    int       regions_checked = 0;
    int       invalid_checked = 0;
    int       cfg_writes      = 0;
    int       burst_left      = 0;
    bit       sender_eager    = 0;
    int       hold_seq        = 0;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Run limit
    initial begin
        #40000000;
        $display("[kd_brick_region_split] ERROR");
        $finish;
    end

    // Bisection walk: box owned by a rank under the given volume settings
    function automatic t_region split_region(input logic [RANK_W-1:0] rank, input t_cfg c);
        t_region         r;
        int unsigned     n;
        int unsigned     sub;
        int unsigned     left;
        int unsigned     cut;
        int unsigned     ext[3];
        int unsigned     lo[3];
        int unsigned     hi[3];
        int unsigned     sz[3];
        int              axis;
        longint unsigned lw;
        longint unsigned sw;
        r = '0;
        r.brick_id = rank;
        n = c.num_ranks;
        if (n > RANK_LIMIT) begin
            n = RANK_LIMIT;
        end
        sub = rank;
        if (sub >= n) begin
            return r;
        end
        ext[0] = c.extent_x;
        ext[1] = c.extent_y;
        ext[2] = c.extent_z;
        for (int k = 0; k < 3; k++) begin
            lo[k] = 0;
            hi[k] = (ext[k] == 0) ? 0 : ext[k] - 1;
        end
        while (n > 1) begin
            left = n / 2;
            for (int k = 0; k < 3; k++) begin
                sz[k] = hi[k] - lo[k];
            end
            axis = 0;
            if (sz[1] > sz[axis]) axis = 1;
            if (sz[2] > sz[axis]) axis = 2;
            lw  = left;
            sw  = sz[axis];
            cut = lo[axis] + int'((lw * sw) / n);
            // Keep the shared plane on both sides, descend into the owning half
            if (sub >= left) begin
                lo[axis] = cut;
                sub      = sub - left;
                n        = n - left;
            end else begin
                hi[axis] = cut;
                n        = left;
            end
        end
        r.low_x   = lo[0][COORD_W-1:0];
        r.low_y   = lo[1][COORD_W-1:0];
        r.low_z   = lo[2][COORD_W-1:0];
        r.high_x  = hi[0][COORD_W-1:0];
        r.high_y  = hi[1][COORD_W-1:0];
        r.high_z  = hi[2][COORD_W-1:0];
        r.rank_ok = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // APB read of one register, compared with the value it should hold
    task automatic read_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] want);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        check_field($sformatf("prdata of register %0d", idx), want, prdata);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // APB write, then read back the masked value
    task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] stored;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        stored = '0;
        case (idx)
            REG_NUM_RANKS: begin
                volume_cfg.num_ranks = value[NRANK_W-1:0];
                stored[NRANK_W-1:0]  = value[NRANK_W-1:0];
            end
            REG_EXTENT_X: begin
                volume_cfg.extent_x = value[COORD_W-1:0];
                stored[COORD_W-1:0] = value[COORD_W-1:0];
            end
            REG_EXTENT_Y: begin
                volume_cfg.extent_y = value[COORD_W-1:0];
                stored[COORD_W-1:0] = value[COORD_W-1:0];
            end
            default: begin
                volume_cfg.extent_z = value[COORD_W-1:0];
                stored[COORD_W-1:0] = value[COORD_W-1:0];
            end
        endcase
        cfg_writes++;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        read_reg(idx, stored);
    endtask

    // Lower valid and hold until every expected box has come back
    task automatic drain_regions();
        @(negedge i_clk);
        req_ch.valid = 1'b0;
        burst_left   = 0;
        while (region_queue.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Idle the block, then load a full volume setting
    task automatic set_volume(input logic [PDATA_W-1:0] ranks, input logic [PDATA_W-1:0] ex,
                              input logic [PDATA_W-1:0] ey, input logic [PDATA_W-1:0] ez);
        drain_regions();
        write_reg(REG_NUM_RANKS, ranks);
        write_reg(REG_EXTENT_X, ex);
        write_reg(REG_EXTENT_Y, ey);
        write_reg(REG_EXTENT_Z, ez);
    endtask

    // Offer one rank, with bursts and gaps unless the sender is eager
    task automatic send_rank(input int unsigned rank);
        int gap;
        if (burst_left == 0) begin
            gap = (sender_eager || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge i_clk);
        req_ch.valid   = 1'b1;
        req_ch.rank_in = RANK_W'(rank);
        do @(posedge i_clk); while (!(req_ch.valid && req_ch.ready));
        region_queue = {region_queue, split_region(RANK_W'(rank), volume_cfg)};
        ranks_sent++;
    endtask

    // Random pick of noise for the unused upper bits of a register write
    function automatic logic [PDATA_W-1:0] upper_noise(input int width);
        logic [PDATA_W-1:0] v;
        v = ($urandom_range(0, 3) == 0) ? $urandom() : '0;
        return v & ~((32'h1 << width) - 1);
    endfunction

    function automatic logic [PDATA_W-1:0] pick_extent();
        logic [PDATA_W-1:0] e;
        case ($urandom_range(0, 7))
            0:       e = 0;
            1:       e = 65535;
            2:       e = 1;
            3, 4:    e = $urandom_range(1, 64);
            default: e = $urandom_range(1, 65535);
        endcase
        return e | upper_noise(COORD_W);
    endfunction

    // Receiver: own stall pattern, plus a long hold-off on request
    initial begin
        int rx_cycle;
        int rx_mode;
        int rx_hold;
        int rx_seen;
        rx_cycle = 0;
        rx_mode  = 0;
        rx_hold  = 0;
        rx_seen  = 0;
        resp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle % 80 == 0) begin
                rx_mode = $urandom_range(0, 3);
            end
            if (hold_seq != rx_seen) begin
                rx_seen = hold_seq;
                rx_hold = HOLD_CYCLES;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                resp_ch.ready = 1'b0;
            end else begin
                case (rx_mode)
                    0:       resp_ch.ready = 1'b1;
                    1:       resp_ch.ready = ($urandom_range(0, 3) != 0);
                    2:       resp_ch.ready = ($urandom_range(0, 3) == 0);
                    default: resp_ch.ready = ((rx_cycle % 7) < 4);
                endcase
            end
        end
    end

    // Compare each returned box with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && resp_ch.valid && resp_ch.ready) begin
            if (region_queue.size() == 0) begin
                $error("unexpected brick region for rank %0d", resp_ch.brick_id);
                mismatch_count++;
            end else begin
                region_due = region_queue.pop_front();
                check_field("brick_id", region_due.brick_id, resp_ch.brick_id);
                check_field("low_x", region_due.low_x, resp_ch.low_x);
                check_field("low_y", region_due.low_y, resp_ch.low_y);
                check_field("low_z", region_due.low_z, resp_ch.low_z);
                check_field("high_x", region_due.high_x, resp_ch.high_x);
                check_field("high_y", region_due.high_y, resp_ch.high_y);
                check_field("high_z", region_due.high_z, resp_ch.high_z);
                check_field("rank_ok", region_due.rank_ok, resp_ch.rank_ok);
                regions_checked++;
                if (!region_due.rank_ok) invalid_checked++;
            end
        end
    end

    // Reset values: a single rank owning a one-voxel volume
    task automatic test_reset_state();
        read_reg(REG_NUM_RANKS, 1);
        read_reg(REG_EXTENT_X, 1);
        read_reg(REG_EXTENT_Y, 1);
        read_reg(REG_EXTENT_Z, 1);
        send_rank(0);
        send_rank(1);
        send_rank(1023);
    endtask

    // Extremes and special cases
    task automatic test_directed_regions();
        // Full rank count over the largest volume
        set_volume(1024, 65535, 65535, 65535);
        send_rank(0);
        send_rank(1);
        send_rank(511);
        send_rank(512);
        send_rank(1023);
        // Rank count above the maximum, with noise above the register
        set_volume(32'hFFFF_F7FF, 65535, 1, 300);
        send_rank(1023);
        send_rank(0);
        // Zero rank count makes every rank invalid
        set_volume(0, 10, 10, 10);
        send_rank(0);
        send_rank(5);
        // Zero extents collapse each axis to one plane
        set_volume(3, 0, 0, 0);
        for (int r = 0; r < 4; r++) send_rank(r);
        // Wide extent keeps its low bits; equal sizes tie towards x
        set_volume(5, 32'hABCD_0007, 7, 7);
        for (int r = 0; r < 5; r++) send_rank(r);
    endtask

    // Long receiver hold-off while ranks keep coming, so the input stalls
    task automatic test_output_hold();
        set_volume(1024, $urandom_range(1, 65535), $urandom_range(1, 65535), 40000);
        sender_eager = 1;
        hold_seq++;
        for (int i = 0; i < 16; i++) send_rank($urandom_range(0, 1023));
        sender_eager = 0;
    endtask

    // Sender pauses mid-stream until the block has returned everything
    task automatic test_sender_pause();
        set_volume(37, 900, 12, 3000);
        for (int i = 0; i < 20; i++) send_rank($urandom_range(0, 40));
        drain_regions();
        for (int i = 0; i < 20; i++) send_rank($urandom_range(0, 40));
    endtask

    // Random volume settings, mostly valid ranks
    task automatic test_random_regions();
        logic [PDATA_W-1:0] ranks;
        int unsigned        n_eff;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case ($urandom_range(0, 9))
                0:          ranks = 0;
                1:          ranks = 1;
                2:          ranks = 1024;
                3:          ranks = $urandom_range(1025, 2047);
                4, 5, 6:    ranks = $urandom_range(2, 16);
                default:    ranks = $urandom_range(1, 1024);
            endcase
            set_volume(ranks | upper_noise(NRANK_W), pick_extent(), pick_extent(),
                       pick_extent());
            n_eff = (volume_cfg.num_ranks > RANK_LIMIT) ? RANK_LIMIT : volume_cfg.num_ranks;
            sender_eager = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (n_eff > 0 && $urandom_range(0, 99) < 85) begin
                    send_rank($urandom_range(0, n_eff - 1));
                end else begin
                    send_rank($urandom_range(0, 1023));
                end
            end
        end
        sender_eager = 0;
    endtask

    // Main sequence
    initial begin
        i_rst_n        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.rank_in = '0;
        volume_cfg     = '{num_ranks: 1, extent_x: 1, extent_y: 1, extent_z: 1};
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_state();
        test_directed_regions();
        test_output_hold();
        test_sender_pause();
        test_random_regions();

        drain_regions();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (region_queue.size() != 0) begin
            $error("%0d brick regions never returned", region_queue.size());
            mismatch_count++;
        end

        $display("Sent %0d rank requests over %0d register writes; checked %0d boxes",
                 ranks_sent, cfg_writes, regions_checked);
        $display("of which %0d flagged invalid ranks, with %0d field mismatches",
                 invalid_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[kd_brick_region_split] OK");
        end else begin
            $display("[kd_brick_region_split] ERROR");
        end
        $finish;
    end

endmodule
